/* hdl/fvm_pkg.sv */
`default_nettype none

package fvm_pkg;

   // default number of field bytes kept for range decoding
   localparam int MAX_BYTES_DEFAULT = 8;

   // widths of the configuration port
   localparam int CSR_INDEX_W = 3;
   localparam int CSR_DATA_W  = 64;

   // configuration register indexes
   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_MATCH_ENABLE   = 3'd0,
      CSR_MATCH_MODE     = 3'd1,
      CSR_VALUE_KIND     = 3'd2,
      CSR_BIG_ENDIAN     = 3'd3,
      CSR_FIRST_OPERAND  = 3'd4,
      CSR_FIRST_LENGTH   = 3'd5,
      CSR_SECOND_OPERAND = 3'd6,
      CSR_SECOND_LENGTH  = 3'd7
   } csr_index_type;

   // match modes, codes 5 to 7 never match
   typedef enum logic [2:0] {
      MODE_EXACT  = 3'd0,
      MODE_PREFIX = 3'd1,
      MODE_MASK   = 3'd2,
      MODE_RANGE  = 3'd3,
      MODE_ANY    = 3'd4
   } mode_type;

   // integer size of a range decode, upper two bits of value_kind
   typedef enum logic [1:0] {
      SIZE_8  = 2'd0,
      SIZE_16 = 2'd1,
      SIZE_32 = 2'd2,
      SIZE_64 = 2'd3
   } size_type;

   // reset values of the registers that do not reset to zero
   localparam logic [2:0] VALUE_KIND_RESET = 3'd2;
   localparam logic       BIG_ENDIAN_RESET = 1'b1;

   // configuration as seen by the matching logic
   typedef struct packed {
      logic        match_enable;
      logic [2:0]  match_mode;
      logic [2:0]  value_kind;
      logic        big_endian;
      logic [63:0] first_operand;
      logic [3:0]  first_length;
      logic [63:0] second_operand;
      logic [3:0]  second_length;
   } cfg_type;

endpackage

`default_nettype wire

/* hdl/fvm_csr_regs.sv */
`default_nettype none

module fvm_csr_regs
   import fvm_pkg::*;
(
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   csr_write_enable,
   input  wire logic [CSR_INDEX_W-1:0] csr_index,
   input  wire logic [CSR_DATA_W-1:0]  csr_write_data,
   output cfg_type                     cfg
);

   // register values after reset
   localparam cfg_type CFG_RESET = '{
      match_enable:   1'b0,
      match_mode:     3'd0,
      value_kind:     VALUE_KIND_RESET,
      big_endian:     BIG_ENDIAN_RESET,
      first_operand:  64'd0,
      first_length:   4'd0,
      second_operand: 64'd0,
      second_length:  4'd0
   };

   cfg_type cfg_ff;
   cfg_type cfg_in;

   // register write decode
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write_enable) begin
         unique case (csr_index_type'(csr_index))
            CSR_MATCH_ENABLE:   cfg_in.match_enable   = csr_write_data[0];
            CSR_MATCH_MODE:     cfg_in.match_mode     = csr_write_data[2:0];
            CSR_VALUE_KIND:     cfg_in.value_kind     = csr_write_data[2:0];
            CSR_BIG_ENDIAN:     cfg_in.big_endian     = csr_write_data[0];
            CSR_FIRST_OPERAND:  cfg_in.first_operand  = csr_write_data[63:0];
            CSR_FIRST_LENGTH:   cfg_in.first_length   = csr_write_data[3:0];
            CSR_SECOND_OPERAND: cfg_in.second_operand = csr_write_data[63:0];
            CSR_SECOND_LENGTH:  cfg_in.second_length  = csr_write_data[3:0];
            default:            cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= CFG_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

`default_nettype wire

/* hdl/fvm_field_track.sv */
`default_nettype none

module fvm_field_track
   import fvm_pkg::*;
#(
   parameter int MAX_BYTES = MAX_BYTES_DEFAULT
) (
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire cfg_type    cfg,
   input  wire logic       step,
   input  wire logic [7:0] data_byte,
   input  wire logic       last_byte,
   output logic            matched
);

   localparam logic [3:0] MAX_LEN = 4'(MAX_BYTES);
   localparam logic [3:0] COUNT_MAX = 4'd15;

   // running field state
   logic [3:0]             count_ff, count_in;
   logic                   bytes_equal_ff, bytes_equal_in;
   logic                   mask_equal_ff, mask_equal_in;
   logic [8*MAX_BYTES-1:0] gathered_ff, gathered_in;

   logic [3:0]  first_len;
   logic [3:0]  second_len;
   logic [7:0]  expect_byte;
   logic [7:0]  compare_byte;
   logic [63:0] gathered_wide;
   logic [63:0] raw_value;
   logic [63:0] field_value;
   logic [3:0]  need_len;
   logic        in_range;

   // operand lengths above the kept bytes count as the kept bytes
   assign first_len  = (cfg.first_length > MAX_LEN) ? MAX_LEN : cfg.first_length;
   assign second_len = (cfg.second_length > MAX_LEN) ? MAX_LEN : cfg.second_length;

   // operand bytes at the current position
   always_comb begin
      expect_byte  = '0;
      compare_byte = '0;
      for (int k = 0; k < 8; k++) begin
         if (count_ff == 4'(k)) begin
            expect_byte  = cfg.first_operand[8*k +: 8];
            compare_byte = cfg.second_operand[8*k +: 8];
         end
      end
      if (count_ff >= second_len) begin
         compare_byte = '0;
      end
   end

   // state update for this word
   always_comb begin
      bytes_equal_in = bytes_equal_ff;
      mask_equal_in  = mask_equal_ff;
      gathered_in    = gathered_ff;
      if (count_ff < first_len) begin
         if (data_byte != expect_byte) begin
            bytes_equal_in = 1'b0;
         end
         if ((data_byte & expect_byte) != compare_byte) begin
            mask_equal_in = 1'b0;
         end
      end
      for (int k = 0; k < MAX_BYTES; k++) begin
         if (count_ff == 4'(k)) begin
            gathered_in[8*k +: 8] = data_byte;
         end
      end
      count_in = (count_ff == COUNT_MAX) ? COUNT_MAX : count_ff + 4'd1;
   end

   // range decode of the gathered bytes
   assign gathered_wide = 64'(gathered_in);
   assign need_len      = 4'd1 << cfg.value_kind[2:1];

   always_comb begin
      raw_value   = '0;
      field_value = '0;
      unique case (size_type'(cfg.value_kind[2:1]))
         SIZE_8: begin
            raw_value   = {56'b0, gathered_wide[7:0]};
            field_value = cfg.value_kind[0] ? 64'($signed(raw_value[7:0])) : raw_value;
         end
         SIZE_16: begin
            raw_value = cfg.big_endian
               ? {48'b0, gathered_wide[7:0], gathered_wide[15:8]}
               : {48'b0, gathered_wide[15:0]};
            field_value = cfg.value_kind[0] ? 64'($signed(raw_value[15:0])) : raw_value;
         end
         SIZE_32: begin
            raw_value = cfg.big_endian
               ? {32'b0, gathered_wide[7:0], gathered_wide[15:8],
                  gathered_wide[23:16], gathered_wide[31:24]}
               : {32'b0, gathered_wide[31:0]};
            field_value = cfg.value_kind[0] ? 64'($signed(raw_value[31:0])) : raw_value;
         end
         SIZE_64: begin
            raw_value = cfg.big_endian
               ? {gathered_wide[7:0], gathered_wide[15:8], gathered_wide[23:16],
                  gathered_wide[31:24], gathered_wide[39:32], gathered_wide[47:40],
                  gathered_wide[55:48], gathered_wide[63:56]}
               : gathered_wide;
            // unsigned values past the signed maximum decode as zero
            field_value = (!cfg.value_kind[0] && raw_value[63]) ? '0 : raw_value;
         end
         default: begin
            raw_value   = '0;
            field_value = '0;
         end
      endcase
      // too few bytes in the field, or more than are kept
      if (need_len > MAX_LEN || count_in < need_len) begin
         field_value = '0;
      end
   end

   assign in_range = ($signed(cfg.first_operand) <= $signed(field_value))
                  && ($signed(field_value) <= $signed(cfg.second_operand));

   // decision on the final byte
   always_comb begin
      matched = 1'b1;
      if (cfg.match_enable) begin
         unique case (cfg.match_mode)
            MODE_EXACT:  matched = bytes_equal_in && (count_in == first_len);
            MODE_PREFIX: matched = bytes_equal_in && (count_in >= first_len);
            MODE_MASK:   matched = mask_equal_in && (count_in == first_len);
            MODE_RANGE:  matched = in_range;
            MODE_ANY:    matched = 1'b1;
            default:     matched = 1'b0;
         endcase
      end
   end

   // field state, cleared after the final byte
   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff       <= '0;
         bytes_equal_ff <= 1'b1;
         mask_equal_ff  <= 1'b1;
         gathered_ff    <= '0;
      end else if (step) begin
         if (last_byte) begin
            count_ff       <= '0;
            bytes_equal_ff <= 1'b1;
            mask_equal_ff  <= 1'b1;
            gathered_ff    <= '0;
         end else begin
            count_ff       <= count_in;
            bytes_equal_ff <= bytes_equal_in;
            mask_equal_ff  <= mask_equal_in;
            gathered_ff    <= gathered_in;
         end
      end
   end

endmodule

`default_nettype wire

/* hdl/field_value_matcher_unit.sv */
// Field value matcher: checks one received protocol field, one byte per word,
// against the configured rule (exact, prefix, mask, signed range or any).
// Request channel: req_data_byte and req_last_byte, with req_valid and
// req_stall; a word is taken at an edge where req_valid is high and
// req_stall low. Response channel: one rsp_matched word per field, issued
// for the word that carries req_last_byte; other words give no response.
// A final byte is taken into the input register; its result is then held in
// the result register and shown on rsp_valid. Throughput: one byte per cycle,
// set by the single input and result registers, unless a final byte waits.
// When the receiver stalls, the result register holds; bytes that are not
// final keep flowing, and a final byte waits in the input register, which
// then raises req_stall until the result slot frees.
// Reset (synchronous, active high) empties both registers, clears the field
// state and returns all configuration registers to their reset values.
// Configuration is written through csr_write_enable, csr_index and
// csr_write_data, by the user only while no field is in progress (unchecked).
`default_nettype none

module field_value_matcher_unit
   import fvm_pkg::*;
#(
   parameter int MAX_BYTES = MAX_BYTES_DEFAULT
) (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   req_valid,
   output logic                        req_stall,
   input  wire logic [7:0]             req_data_byte,
   input  wire logic                   req_last_byte,
   output logic                        rsp_valid,
   input  wire logic                   rsp_stall,
   output logic                        rsp_matched,
   input  wire logic                   csr_write_enable,
   input  wire logic [CSR_INDEX_W-1:0] csr_index,
   input  wire logic [CSR_DATA_W-1:0]  csr_write_data
);

   cfg_type cfg;

   logic       in_valid_ff, in_valid_in;
   logic [7:0] in_byte_ff;
   logic       in_last_ff;
   logic       rsp_valid_ff, rsp_valid_in;
   logic       rsp_matched_ff;
   logic       out_free;
   logic       step;
   logic       req_take;
   logic       matched;

   fvm_csr_regs u_csr (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data),
      .cfg              (cfg)
   );

   fvm_field_track #(
      .MAX_BYTES (MAX_BYTES)
   ) u_track (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg),
      .step      (step),
      .data_byte (in_byte_ff),
      .last_byte (in_last_ff),
      .matched   (matched)
   );

   // flow control: only a final byte needs the result slot
   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign step      = in_valid_ff && (!in_last_ff || out_free);
   assign req_stall = in_valid_ff && !step;
   assign req_take  = req_valid && !req_stall;

   // next occupancy of both registers
   always_comb begin
      in_valid_in = in_valid_ff;
      if (req_take) begin
         in_valid_in = 1'b1;
      end else if (step) begin
         in_valid_in = 1'b0;
      end
      rsp_valid_in = rsp_valid_ff;
      if (step && in_last_ff) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   // input register
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         in_byte_ff <= req_data_byte;
         in_last_ff <= req_last_byte;
      end
   end

   // result register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (step && in_last_ff) begin
         rsp_matched_ff <= matched;
      end
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_matched = rsp_matched_ff;

`ifndef SYNTHESIS
   // a processed final byte always lands in the result register
   assert property (@(posedge clock) disable iff (reset)
      step && in_last_ff |=> rsp_valid)
      else $error("final byte processed without a result");

   // stall only when a final byte waits behind a stalled result
   assert property (@(posedge clock) disable iff (reset)
      req_stall |-> in_valid_ff && in_last_ff && rsp_valid_ff && rsp_stall)
      else $error("request stalled without cause");

   // with matching off every field passes
   assert property (@(posedge clock) disable iff (reset)
      step && in_last_ff && !cfg.match_enable |=> rsp_matched)
      else $error("field failed with matching off");
`endif

endmodule

`default_nettype wire

/* tb/sv/field_match_checker.sv */
`default_nettype none

module field_match_checker
   import fvm_pkg::*;
(
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   req_valid,
   input  wire logic                   req_stall,
   input  wire logic [7:0]             req_data_byte,
   input  wire logic                   req_last_byte,
   input  wire logic                   rsp_valid,
   input  wire logic                   rsp_stall,
   input  wire logic                   rsp_matched,
   input  wire logic                   csr_write_enable,
   input  wire logic [CSR_INDEX_W-1:0] csr_index,
   input  wire logic [CSR_DATA_W-1:0]  csr_write_data,
   output int unsigned                 mismatch_count,
   output int unsigned                 pending_results,
   output int unsigned                 results_checked,
   output int unsigned                 results_matched
);

   // shadow copy of the configuration and the running field state
   cfg_type     field_rule;
   logic [3:0]  byte_count;
   logic        bytes_equal;
   logic        mask_equal;
   logic [63:0] gathered_bytes;

   // predicted match flags, oldest first
   logic        expected_matches[$];

   function automatic logic [3:0] clamp_length(input logic [3:0] n);
      return (n > MAX_BYTES_DEFAULT) ? 4'(MAX_BYTES_DEFAULT) : n;
   endfunction

   // integer value of the gathered bytes as 64-bit two's complement
   function automatic logic [63:0] decoded_value();
      int unsigned n;
      int unsigned i;
      int unsigned pos;
      logic [63:0] v;
      n = 1 << field_rule.value_kind[2:1];
      v = '0;
      if (n > MAX_BYTES_DEFAULT || byte_count < n) begin
         return '0;
      end
      for (i = 0; i < n; i++) begin
         pos = field_rule.big_endian ? (n - 1 - i) : i;
         v[8*pos +: 8] = gathered_bytes[8*i +: 8];
      end
      if (n < 8) begin
         if (field_rule.value_kind[0] && v[8*n-1]) begin
            v = v | ~((64'd1 << (8*n)) - 64'd1);
         end
      end else if (!field_rule.value_kind[0] && v[63]) begin
         // unsigned 64-bit values past the signed maximum read as zero
         v = '0;
      end
      return v;
   endfunction

   // decision on the final byte of a field
   function automatic logic field_passes();
      logic [63:0] v;
      if (!field_rule.match_enable) begin
         return 1'b1;
      end
      case (field_rule.match_mode)
         MODE_EXACT:  return bytes_equal && byte_count == clamp_length(field_rule.first_length);
         MODE_PREFIX: return bytes_equal && byte_count >= clamp_length(field_rule.first_length);
         MODE_MASK:   return mask_equal && byte_count == clamp_length(field_rule.first_length);
         MODE_RANGE: begin
            v = decoded_value();
            return ($signed(field_rule.first_operand) <= $signed(v)) &&
                   ($signed(v) <= $signed(field_rule.second_operand));
         end
         MODE_ANY:    return 1'b1;
         default:     return 1'b0;
      endcase
   endfunction

   function automatic void clear_field();
      byte_count     = '0;
      bytes_equal    = 1'b1;
      mask_equal     = 1'b1;
      gathered_bytes = '0;
   endfunction

   // fold one accepted byte into the running flags
   task automatic predict_field_byte(input logic [7:0] b, input logic last);
      logic [3:0] idx;
      logic [7:0] want_byte;
      logic [7:0] cmp_byte;
      idx = byte_count;
      if (idx < clamp_length(field_rule.first_length)) begin
         want_byte = field_rule.first_operand[8*idx +: 8];
         cmp_byte  = (idx < clamp_length(field_rule.second_length)) ?
                     field_rule.second_operand[8*idx +: 8] : 8'h00;
         if (b != want_byte) bytes_equal = 1'b0;
         if ((b & want_byte) != cmp_byte) mask_equal = 1'b0;
      end
      if (idx < MAX_BYTES_DEFAULT) begin
         gathered_bytes[8*idx +: 8] = b;
      end
      if (byte_count != 4'd15) begin
         byte_count = byte_count + 4'd1;
      end
      if (last) begin
         expected_matches.push_back(field_passes());
         clear_field();
      end
   endtask

   task automatic report_mismatch(input string what);
      $display("check: result %0d: %s", results_checked, what);
      mismatch_count++;
   endtask

   // watch all three ports at each edge
   always @(posedge clock) begin
      logic want_match;
      if (reset) begin
         field_rule            = '0;
         field_rule.value_kind = VALUE_KIND_RESET;
         field_rule.big_endian = BIG_ENDIAN_RESET;
         clear_field();
         expected_matches.delete();
         mismatch_count  = 0;
         results_checked = 0;
         results_matched = 0;
      end else begin
         // result word against the oldest prediction
         if (rsp_valid && !rsp_stall) begin
            if (expected_matches.size() == 0) begin
               report_mismatch($sformatf("result word with none due, matched=%b", rsp_matched));
            end else begin
               want_match = expected_matches.pop_front();
               if (rsp_matched !== want_match) begin
                  report_mismatch($sformatf("matched=%b, predicted %b", rsp_matched, want_match));
               end
               if (want_match) results_matched++;
               results_checked++;
            end
         end
         // request word
         if (req_valid && !req_stall) begin
            predict_field_byte(req_data_byte, req_last_byte);
         end
         // register writes
         if (csr_write_enable) begin
            case (csr_index)
               CSR_MATCH_ENABLE:   field_rule.match_enable   = csr_write_data[0];
               CSR_MATCH_MODE:     field_rule.match_mode     = csr_write_data[2:0];
               CSR_VALUE_KIND:     field_rule.value_kind     = csr_write_data[2:0];
               CSR_BIG_ENDIAN:     field_rule.big_endian     = csr_write_data[0];
               CSR_FIRST_OPERAND:  field_rule.first_operand  = csr_write_data;
               CSR_FIRST_LENGTH:   field_rule.first_length   = csr_write_data[3:0];
               CSR_SECOND_OPERAND: field_rule.second_operand = csr_write_data;
               CSR_SECOND_LENGTH:  field_rule.second_length  = csr_write_data[3:0];
               default: ;
            endcase
         end
      end
      pending_results = expected_matches.size();
   end

endmodule

`default_nettype wire

/* tb/sv/field_value_matcher_unit_tb.sv */
`default_nettype none

module field_value_matcher_unit_tb;
   import fvm_pkg::*;

   localparam int unsigned RANDOM_ITEMS = 950;
   localparam int unsigned CYCLE_LIMIT  = 200000;
   localparam int unsigned LONG_HOLD    = 300;

   logic                   clock;
   logic                   reset;
   logic                   req_valid;
   logic                   req_stall;
   logic [7:0]             req_data_byte;
   logic                   req_last_byte;
   logic                   rsp_valid;
   logic                   rsp_stall;
   logic                   rsp_matched;
   logic                   csr_write_enable;
   logic [CSR_INDEX_W-1:0] csr_index;
   logic [CSR_DATA_W-1:0]  csr_write_data;

   int unsigned mismatch_count;
   int unsigned pending_results;
   int unsigned results_checked;
   int unsigned results_matched;

   int unsigned cycle_count = 0;
   int unsigned bytes_sent = 0;
   int unsigned rules_loaded = 0;
   int unsigned send_idle_pct = 0;
   int unsigned rsp_stall_pct = 0;
   bit          hold_req = 1'b0;
   bit          hold_ack;
   int unsigned hold_left;

   // configuration the stimulus currently has loaded
   cfg_type rule;

   field_value_matcher_unit dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_data_byte    (req_data_byte),
      .req_last_byte    (req_last_byte),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_matched      (rsp_matched),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data)
   );

   field_match_checker field_check (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_data_byte    (req_data_byte),
      .req_last_byte    (req_last_byte),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_matched      (rsp_matched),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data),
      .mismatch_count   (mismatch_count),
      .pending_results  (pending_results),
      .results_checked  (results_checked),
      .results_matched  (results_matched)
   );

   // clock and cycle count
   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
   end

   // run limit
   initial begin
      @(posedge clock);
      while (cycle_count < CYCLE_LIMIT) @(posedge clock);
      $display("tb: failure");
      $finish;
   end

   // receiver: random stalls, plus a long hold on request
   initial begin
      rsp_stall = 1'b0;
      hold_ack  = 1'b0;
      hold_left = 0;
      forever @(posedge clock) begin
         if (hold_left != 0) begin
            rsp_stall <= 1'b1;
            hold_left = hold_left - 1;
         end else if (hold_req != hold_ack) begin
            hold_ack  = hold_req;
            hold_left = LONG_HOLD;
            rsp_stall <= 1'b1;
         end else begin
            rsp_stall <= ($urandom_range(0, 99) < rsp_stall_pct);
         end
      end
   end

   // drop valid and wait until every result word is out and the pipe is empty
   task automatic settle();
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending_results != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic csr_write(input csr_index_type idx, input logic [CSR_DATA_W-1:0] data);
      csr_write_enable <= 1'b1;
      csr_index        <= idx;
      csr_write_data   <= data;
      @(posedge clock);
   endtask

   // write every register from the current rule, block idle
   task automatic load_rule();
      settle();
      csr_write(CSR_MATCH_ENABLE,   64'(rule.match_enable));
      csr_write(CSR_MATCH_MODE,     64'(rule.match_mode));
      csr_write(CSR_VALUE_KIND,     64'(rule.value_kind));
      csr_write(CSR_BIG_ENDIAN,     64'(rule.big_endian));
      csr_write(CSR_FIRST_OPERAND,  rule.first_operand);
      csr_write(CSR_FIRST_LENGTH,   64'(rule.first_length));
      csr_write(CSR_SECOND_OPERAND, rule.second_operand);
      csr_write(CSR_SECOND_LENGTH,  64'(rule.second_length));
      csr_write_enable <= 1'b0;
      rules_loaded++;
   endtask

   task automatic set_rule(input logic enable, input logic [2:0] mode, input logic [2:0] kind,
                           input logic big, input logic [63:0] op1, input logic [3:0] len1,
                           input logic [63:0] op2, input logic [3:0] len2);
      rule.match_enable   = enable;
      rule.match_mode     = mode;
      rule.value_kind     = kind;
      rule.big_endian     = big;
      rule.first_operand  = op1;
      rule.first_length   = len1;
      rule.second_operand = op2;
      rule.second_length  = len2;
      load_rule();
   endtask

   // offer one request word after a random gap, return once it is taken
   task automatic send_byte(input logic [7:0] b, input logic last);
      while ($urandom_range(0, 99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid     <= 1'b1;
      req_data_byte <= b;
      req_last_byte <= last;
      @(posedge clock);
      while (req_stall !== 1'b0) @(posedge clock);
      bytes_sent++;
   endtask

   // range bound reduced to what the decode of this kind can produce
   function automatic logic [63:0] fit_to_kind(input logic [63:0] raw, input logic [2:0] kind);
      int unsigned bits;
      bits = 8 << kind[2:1];
      if (bits < 64) begin
         raw = raw & ((64'd1 << bits) - 64'd1);
         if (kind[0] && raw[bits-1]) raw = raw | ~((64'd1 << bits) - 64'd1);
      end else if (!kind[0]) begin
         raw[63] = 1'b0;
      end
      return raw;
   endfunction

   task automatic pick_random_rule();
      int unsigned m;
      logic [63:0] lo;
      logic [63:0] hi;
      logic [63:0] t;
      m = $urandom_range(0, 11);
      rule.match_enable = ($urandom_range(0, 9) != 0);
      rule.match_mode   = (m < 10) ? 3'(m % 5) : 3'($urandom_range(5, 7));
      rule.value_kind   = 3'($urandom_range(0, 7));
      rule.big_endian   = 1'($urandom_range(0, 1));
      rule.first_operand  = {$urandom, $urandom};
      rule.second_operand = {$urandom, $urandom};
      case ($urandom_range(0, 7))
         0: rule.first_operand = '1;
         1: rule.first_operand = '0;
         default: ;
      endcase
      rule.first_length  = ($urandom_range(0, 9) == 0) ? 4'($urandom_range(9, 15))
                                                       : 4'($urandom_range(0, 8));
      rule.second_length = ($urandom_range(0, 9) == 0) ? 4'($urandom_range(9, 15))
                                                       : 4'($urandom_range(0, 8));
      // mask rules mostly with a reachable compare value
      if (rule.match_mode == MODE_MASK && $urandom_range(0, 3) != 0) begin
         rule.second_operand = rule.second_operand & rule.first_operand;
      end
      // range rules: ordered bounds in the kind's domain, some empty, some full
      if (rule.match_mode == MODE_RANGE) begin
         lo = fit_to_kind({$urandom, $urandom}, rule.value_kind);
         hi = fit_to_kind({$urandom, $urandom}, rule.value_kind);
         if ($signed(lo) > $signed(hi)) begin
            t  = lo;
            lo = hi;
            hi = t;
         end
         case ($urandom_range(0, 7))
            0: begin
               t  = lo;
               lo = hi;
               hi = t;
            end
            1: begin
               lo = 64'h8000_0000_0000_0000;
               hi = 64'h7FFF_FFFF_FFFF_FFFF;
            end
            default: ;
         endcase
         rule.first_operand  = lo;
         rule.second_operand = hi;
      end
   endtask

   // one field shaped to the loaded rule, with some corrupted bytes
   task automatic send_random_field();
      int unsigned flen;
      int unsigned slen;
      int unsigned len;
      int unsigned i;
      logic [7:0]  want_byte;
      logic [7:0]  cmp_byte;
      logic [7:0]  b;
      flen = (rule.first_length > 8) ? 8 : rule.first_length;
      slen = (rule.second_length > 8) ? 8 : rule.second_length;
      case (rule.match_mode)
         MODE_EXACT, MODE_MASK: len = (flen == 0) ? 1 : flen;
         MODE_PREFIX:           len = flen + $urandom_range(0, 3);
         MODE_RANGE:            len = 1 << rule.value_kind[2:1];
         default:               len = $urandom_range(1, 6);
      endcase
      if ($urandom_range(0, 9) == 0) len = $urandom_range(1, 20);
      if (len == 0) len = 1;
      for (i = 0; i < len; i++) begin
         b = 8'($urandom);
         if (i < 8) begin
            want_byte = rule.first_operand[8*i +: 8];
            cmp_byte  = (i < slen) ? rule.second_operand[8*i +: 8] : 8'h00;
            case (rule.match_mode)
               MODE_EXACT, MODE_PREFIX: b = want_byte;
               MODE_MASK:               b = (cmp_byte & want_byte) | (b & ~want_byte);
               default: ;
            endcase
         end
         if ($urandom_range(0, 15) == 0) b = 8'($urandom);
         send_byte(b, i == len - 1);
      end
   endtask

   // stimulus
   initial begin
      int unsigned phase;
      int unsigned phase_start;
      bit          pressure_done;
      reset            = 1'b1;
      req_valid        = 1'b0;
      req_data_byte    = 8'h00;
      req_last_byte    = 1'b0;
      csr_write_enable = 1'b0;
      csr_index        = CSR_MATCH_ENABLE;
      csr_write_data   = '0;
      pressure_done    = 1'b0;
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      // matching off: anything passes
      set_rule(1'b0, MODE_EXACT, 3'd2, 1'b1, 64'h0, 4'd0, 64'h0, 4'd0);
      send_byte(8'hFF, 1'b1);
      // exact with no expected bytes never matches
      set_rule(1'b1, MODE_EXACT, 3'd2, 1'b1, 64'h0, 4'd0, 64'h0, 4'd0);
      send_byte(8'h00, 1'b1);
      // exact: equal field, then a short one
      set_rule(1'b1, MODE_EXACT, 3'd2, 1'b1, 64'hCDAB, 4'd2, 64'h0, 4'd0);
      send_byte(8'hAB, 1'b0);
      send_byte(8'hCD, 1'b1);
      send_byte(8'hAB, 1'b1);
      // prefix with no expected bytes always matches
      set_rule(1'b1, MODE_PREFIX, 3'd2, 1'b1, 64'h0, 4'd0, 64'h0, 4'd0);
      send_byte(8'h55, 1'b1);
      // prefix followed by extra bytes
      set_rule(1'b1, MODE_PREFIX, 3'd2, 1'b1, 64'hFF, 4'd1, 64'h0, 4'd0);
      send_byte(8'hFF, 1'b0);
      send_byte(8'h00, 1'b0);
      send_byte(8'h11, 1'b1);
      // mask where the compare value is shorter than the mask
      set_rule(1'b1, MODE_MASK, 3'd2, 1'b1, 64'hF0FF, 4'd2, 64'h12, 4'd1);
      send_byte(8'h12, 1'b0);
      send_byte(8'h0F, 1'b1);
      // signed byte inside [-1, 1], overlong lengths
      set_rule(1'b1, MODE_RANGE, 3'd1, 1'b1, '1, 4'd15, 64'd1, 4'd15);
      send_byte(8'hFF, 1'b1);
      // field too short for a 16-bit decode reads as zero
      set_rule(1'b1, MODE_RANGE, 3'd3, 1'b0, 64'h0, 4'd0, 64'h0, 4'd0);
      send_byte(8'h05, 1'b1);
      // unsigned 64-bit above the signed maximum reads as zero
      set_rule(1'b1, MODE_RANGE, 3'd6, 1'b1, 64'h0, 4'd8, 64'h0, 4'd8);
      send_byte(8'h80, 1'b0);
      repeat (6) send_byte(8'h00, 1'b0);
      send_byte(8'h00, 1'b1);
      // undefined mode code never matches
      set_rule(1'b1, 3'd7, 3'd7, 1'b0, '1, 4'd15, '1, 4'd15);
      send_byte(8'h00, 1'b1);

      // random fields in four idling phases
      for (phase = 0; phase < 4; phase++) begin
         case (phase)
            0: begin send_idle_pct = 0;  rsp_stall_pct = 0;  end
            1: begin send_idle_pct = 49; rsp_stall_pct = 0;  end
            2: begin send_idle_pct = 0;  rsp_stall_pct = 49; end
            default: begin send_idle_pct = 28; rsp_stall_pct = 28; end
         endcase
         phase_start = bytes_sent;
         while (bytes_sent - phase_start < RANDOM_ITEMS / 4) begin
            pick_random_rule();
            load_rule();
            if (!pressure_done) begin
               // receiver holds off while words keep coming, then the sender drains
               hold_req = ~hold_req;
               repeat (8) send_random_field();
               settle();
               pressure_done = 1'b1;
            end else begin
               repeat ($urandom_range(3, 10)) send_random_field();
            end
         end
      end
      settle();
      repeat (8) @(posedge clock);

      $display("run: %0d bytes in %0d fields under %0d register settings, four idling phases",
               bytes_sent, results_checked, rules_loaded);
      $display("run: %0d fields passed their rule, %0d mismatches", results_matched,
               mismatch_count);
      if (mismatch_count == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end

endmodule

`default_nettype wire

/* filelist.f */
hdl/fvm_pkg.sv
hdl/fvm_csr_regs.sv
hdl/fvm_field_track.sv
hdl/field_value_matcher_unit.sv
tb/sv/field_match_checker.sv
tb/sv/field_value_matcher_unit_tb.sv
